[sv/dlefr_pkg.sv]
// dlefr_pkg: constants, codes and widths shared by the frame receiver files
package dlefr_pkg;

    localparam int MAX_PAYLOAD = 16;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

    localparam logic [7:0] ESC_BYTE   = 8'h10;
    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] END_BYTE   = 8'h03;

    localparam logic [7:0] TIMEOUT_RESET = 8'd250;
    localparam logic [7:0] TICK_MAX      = 8'd255;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CHK_LO  = 2'd2;
    localparam logic [1:0] PH_CHK_HI  = 2'd3;

    localparam logic [1:0] EV_DATA   = 2'd0;
    localparam logic [1:0] EV_GOOD   = 2'd1;
    localparam logic [1:0] EV_BADSUM = 2'd2;
    localparam logic [1:0] EV_LONG   = 2'd3;

    typedef logic [CNT_W-1:0] count_t;

endpackage

[sv/dlefr_intf.sv]
// dlefr_intf: valid/ready channel interfaces for line beats and result beats
interface dlefr_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface dlefr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [7:0]  data_byte;
    logic [3:0]  byte_index;
    logic [4:0]  frame_length;
    logic [15:0] received_checksum;
    logic [15:0] computed_checksum;

    modport source (output valid, output event_res, output data_byte, output byte_index,
                    output frame_length, output received_checksum,
                    output computed_checksum, input ready);
    modport sink   (input valid, input event_res, input data_byte, input byte_index,
                    input frame_length, input received_checksum,
                    input computed_checksum, output ready);
endinterface

[sv/dle_frame_receiver.sv]
// dle_frame_receiver: escape-stuffed frame deframer with checksum check and tick timeout
//
//  channel  dir  handshake          beat
//  rx       in   valid/ready        kind, rx_byte
//  res      out  valid/ready        event_res, data_byte, byte_index, frame_length,
//                                   received_checksum, computed_checksum
//  cfg      in   cfg_we             cfg_wdata = timeout_ticks
//
//  one beat per cycle while no stalled result holds rx; a result appears in the cycle after its beat is taken
//  the single result register sets the rate: rx.ready = !res.valid || res.ready
//  reset clears the frame state and loads a timeout of 250 ticks
//  a stalled result holds; rx takes new beats again as soon as it leaves
module dle_frame_receiver
    import dlefr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    dlefr_in_if.sink           rx,
    dlefr_out_if.source        res
);

    logic [7:0]  timeout_reg;
    logic [1:0]  phase_reg,     phase_next;
    logic        esc_reg,       esc_next;
    logic [15:0] sum_reg,       sum_next;
    count_t      count_reg,     count_next;
    logic        ovf_reg,       ovf_next;
    logic [7:0]  chk_low_reg,   chk_low_next;
    logic [7:0]  ticks_reg,     ticks_next;

    logic        out_valid_reg;
    logic [1:0]  ev_reg,        ev_next;
    logic [7:0]  data_reg,      data_next;
    logic [3:0]  index_reg,     index_next;
    logic [4:0]  len_reg,       len_next;
    logic [15:0] rsum_reg,      rsum_next;
    logic [15:0] csum_reg,      csum_next;

    logic        accept;
    logic        emit;
    logic        take_data;
    logic [7:0]  limit;
    logic [7:0]  ticks_inc;
    logic [15:0] rsum;
    logic        clear;

    assign rx.ready = !out_valid_reg || res.ready;
    assign accept   = rx.valid && rx.ready;

    assign limit     = (timeout_reg == 8'd0) ? 8'd1 : timeout_reg;
    assign ticks_inc = (ticks_reg == TICK_MAX) ? ticks_reg : ticks_reg + 8'd1;
    assign rsum      = {rx.rx_byte, chk_low_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        esc_next     = esc_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        chk_low_next = chk_low_reg;
        ticks_next   = ticks_reg;
        emit         = 1'b0;
        take_data    = 1'b0;
        clear        = 1'b0;
        ev_next      = EV_DATA;
        data_next    = 8'd0;
        index_next   = 4'd0;
        len_next     = 5'd0;
        rsum_next    = 16'd0;
        csum_next    = 16'd0;

        if (accept)
        begin
            if (rx.kind == KIND_TICK)
            begin
                ticks_next = ticks_inc;
                if (ticks_inc >= limit)
                begin
                    ticks_next = 8'd0;
                    phase_next = PH_IDLE;
                    esc_next   = 1'b0;
                    clear      = 1'b1;
                end
            end
            else
            begin
                ticks_next = 8'd0;
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                    case (rx.rx_byte)
                        ESC_BYTE:
                        begin
                            take_data = 1'b1;
                        end
                        START_BYTE:
                        begin
                            clear      = 1'b1;
                            phase_next = PH_PAYLOAD;
                        end
                        END_BYTE:
                        begin
                            if (phase_reg == PH_PAYLOAD)
                            begin
                                phase_next = PH_CHK_LO;
                            end
                        end
                        default:
                        begin
                            // unknown escape pair is dropped
                        end
                    endcase
                end
                else if (rx.rx_byte == ESC_BYTE)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    take_data = 1'b1;
                end
            end
        end

        if (clear)
        begin
            sum_next     = 16'd0;
            count_next   = '0;
            ovf_next     = 1'b0;
            chk_low_next = 8'd0;
        end

        if (take_data)
        begin
            case (phase_reg)
                PH_PAYLOAD:
                begin
                    if (count_reg < count_t'(MAX_PAYLOAD))
                    begin
                        emit       = 1'b1;
                        ev_next    = EV_DATA;
                        data_next  = rx.rx_byte;
                        index_next = 4'(count_reg);
                        sum_next   = sum_reg + {8'd0, rx.rx_byte};
                        count_next = count_reg + count_t'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                PH_CHK_LO:
                begin
                    chk_low_next = rx.rx_byte;
                    phase_next   = PH_CHK_HI;
                end
                PH_CHK_HI:
                begin
                    emit       = 1'b1;
                    len_next   = 5'(count_reg);
                    rsum_next  = rsum;
                    csum_next  = sum_reg;
                    phase_next = PH_IDLE;
                    if (ovf_reg)
                    begin
                        ev_next = EV_LONG;
                    end
                    else if (rsum == sum_reg)
                    begin
                        ev_next = EV_GOOD;
                    end
                    else
                    begin
                        ev_next = EV_BADSUM;
                    end
                end
                default:
                begin
                    // plain bytes outside a frame are ignored
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            phase_reg     <= PH_IDLE;
            esc_reg       <= 1'b0;
            sum_reg       <= 16'd0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            chk_low_reg   <= 8'd0;
            ticks_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            phase_reg   <= phase_next;
            esc_reg     <= esc_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            chk_low_reg <= chk_low_next;
            ticks_reg   <= ticks_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ev_reg    <= ev_next;
            data_reg  <= data_next;
            index_reg <= index_next;
            len_reg   <= len_next;
            rsum_reg  <= rsum_next;
            csum_reg  <= csum_next;
        end
    end

    assign res.valid             = out_valid_reg;
    assign res.event_res         = ev_reg;
    assign res.data_byte         = data_reg;
    assign res.byte_index        = index_reg;
    assign res.frame_length      = len_reg;
    assign res.received_checksum = rsum_reg;
    assign res.computed_checksum = csum_reg;

    // a good frame carries matching checksums
    a_good_match: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.event_res == EV_GOOD) |->
            (res.received_checksum == res.computed_checksum))
        else $error("good frame with mismatched checksums");

    // payload beats carry no frame summary
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.event_res == EV_DATA) |->
            (res.frame_length == 5'd0 && res.received_checksum == 16'd0
             && res.computed_checksum == 16'd0))
        else $error("payload beat with frame summary fields");

    // input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> res.valid)
        else $error("rx stalled with no pending result");

    // a tick never produces a result
    a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rx.kind == KIND_TICK) |=>
            (!out_valid_reg || $past(out_valid_reg && !res.ready)))
        else $error("tick produced a result");

    // kept payload never exceeds the buffer
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(MAX_PAYLOAD))
        else $error("payload count beyond buffer size");

endmodule

[sim/tb_dle_frame_receiver.sv]
// tb_dle_frame_receiver: random and directed frame traffic checked against an event predictor
module tb_dle_frame_receiver
    import dlefr_pkg::*;
;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  data_byte;
        logic [3:0]  byte_index;
        logic [4:0]  frame_length;
        logic [15:0] received_checksum;
        logic [15:0] computed_checksum;
    } frame_event_t;

    class frame_scoreboard;
        logic [7:0]   timeout;
        logic [1:0]   phase;
        bit           escape_armed;
        logic [15:0]  payload_sum;
        count_t       payload_count;
        bit           too_long;
        logic [7:0]   chk_low;
        logic [7:0]   tick_count;
        frame_event_t pending_events[$];
        int           errors;

        function new();
            timeout = TIMEOUT_RESET;
            phase = PH_IDLE;
            escape_armed = 0;
            tick_count = '0;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            payload_sum = '0;
            payload_count = '0;
            too_long = 0;
            chk_low = '0;
        endfunction

        function void take_data(input logic [7:0] b);
            frame_event_t ev;
            logic [15:0] rsum;
            ev = '0;
            if (phase == PH_PAYLOAD)
            begin
                if (payload_count < MAX_PAYLOAD)
                begin
                    ev.event_res = EV_DATA;
                    ev.data_byte = b;
                    ev.byte_index = payload_count[3:0];
                    pending_events.push_back(ev);
                    payload_sum = payload_sum + {8'h00, b};
                    payload_count = payload_count + 1'b1;
                end
                else
                begin
                    too_long = 1;
                end
            end
            else if (phase == PH_CHK_LO)
            begin
                chk_low = b;
                phase = PH_CHK_HI;
            end
            else if (phase == PH_CHK_HI)
            begin
                rsum = {b, chk_low};
                if (too_long)
                    ev.event_res = EV_LONG;
                else if (rsum == payload_sum)
                    ev.event_res = EV_GOOD;
                else
                    ev.event_res = EV_BADSUM;
                ev.frame_length = 5'(payload_count);
                ev.received_checksum = rsum;
                ev.computed_checksum = payload_sum;
                pending_events.push_back(ev);
                phase = PH_IDLE;
            end
        endfunction

        function void note_beat(input logic kind, input logic [7:0] b);
            logic [7:0] limit;
            if (kind == KIND_TICK)
            begin
                limit = (timeout == 8'd0) ? 8'd1 : timeout;
                if (tick_count < TICK_MAX)
                    tick_count = tick_count + 1'b1;
                if (tick_count >= limit)
                begin
                    tick_count = '0;
                    phase = PH_IDLE;
                    escape_armed = 0;
                    clear_frame();
                end
                return;
            end
            tick_count = '0;
            if (escape_armed)
            begin
                escape_armed = 0;
                if (b == ESC_BYTE)
                begin
                    take_data(b);
                end
                else if (b == START_BYTE)
                begin
                    clear_frame();
                    phase = PH_PAYLOAD;
                end
                else if (b == END_BYTE && phase == PH_PAYLOAD)
                begin
                    phase = PH_CHK_LO;
                end
            end
            else if (b == ESC_BYTE)
            begin
                escape_armed = 1;
            end
            else
            begin
                take_data(b);
            end
        endfunction

        function void check(input frame_event_t got);
            frame_event_t exp;
            if (pending_events.size() == 0)
            begin
                $error("unexpected result beat, event_res %0d", got.event_res);
                errors++;
                return;
            end
            exp = pending_events.pop_front();
            if (got.event_res !== exp.event_res)
            begin
                $error("event_res: expected %0d, got %0d", exp.event_res, got.event_res);
                errors++;
            end
            if (got.data_byte !== exp.data_byte)
            begin
                $error("data_byte: expected %0h, got %0h", exp.data_byte, got.data_byte);
                errors++;
            end
            if (got.byte_index !== exp.byte_index)
            begin
                $error("byte_index: expected %0d, got %0d", exp.byte_index, got.byte_index);
                errors++;
            end
            if (got.frame_length !== exp.frame_length)
            begin
                $error("frame_length: expected %0d, got %0d", exp.frame_length,
                       got.frame_length);
                errors++;
            end
            if (got.received_checksum !== exp.received_checksum)
            begin
                $error("received_checksum: expected %0h, got %0h", exp.received_checksum,
                       got.received_checksum);
                errors++;
            end
            if (got.computed_checksum !== exp.computed_checksum)
            begin
                $error("computed_checksum: expected %0h, got %0h", exp.computed_checksum,
                       got.computed_checksum);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    dlefr_in_if  rx_if ();
    dlefr_out_if res_if ();

    dle_frame_receiver uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx        (rx_if),
        .res       (res_if)
    );

    frame_scoreboard sb;
    bit              rx_calm;
    bit              res_calm;
    int              beats_sent;
    int              cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("dle_frame_receiver: mismatch");
            $finish;
        end
    end

    task automatic send_beat(input logic kind, input logic [7:0] b);
        int gap;
        gap = rx_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.kind <= kind;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!(rx_if.valid && rx_if.ready === 1'b1));
        sb.note_beat(kind, b);
        beats_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(KIND_BYTE, b);
    endtask

    task automatic send_tick();
        send_beat(KIND_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_escaped(input logic [7:0] b);
        send_byte(ESC_BYTE);
        send_byte(b);
    endtask

    task automatic send_stuffed(input logic [7:0] b);
        if (b == ESC_BYTE)
            send_byte(ESC_BYTE);
        send_byte(b);
    endtask

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 7))
            0: return ESC_BYTE;
            1: return START_BYTE;
            2: return END_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input int len, input bit good_sum, input int tick_odds);
        logic [15:0] sum;
        logic [15:0] chk;
        logic [7:0]  b;
        sum = '0;
        send_escaped(START_BYTE);
        for (int i = 0; i < len; i++)
        begin
            b = pick_payload();
            if (tick_odds > 0 && $urandom_range(0, tick_odds) == 0)
                send_tick();
            send_stuffed(b);
            if (i < MAX_PAYLOAD)
                sum = sum + {8'h00, b};
        end
        send_escaped(END_BYTE);
        chk = good_sum ? sum : 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 7) == 0)
            chk[7:0] = ESC_BYTE;
        send_stuffed(chk[7:0]);
        send_stuffed(chk[15:8]);
    endtask

    task automatic send_noise();
        int n;
        case ($urandom_range(0, 5))
            0: send_byte(8'($urandom_range(0, 255)));
            1: send_tick();
            2: send_escaped(8'($urandom_range(0, 255)));
            3:
            begin
                // frame cut short, next start abandons it
                send_escaped(START_BYTE);
                n = $urandom_range(0, 5);
                repeat (n) send_stuffed(pick_payload());
            end
            4:
            begin
                // only one checksum byte before a restart
                send_escaped(START_BYTE);
                send_stuffed(pick_payload());
                send_escaped(END_BYTE);
                send_stuffed(pick_payload());
            end
            default:
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_tick();
            end
        endcase
    endtask

    task automatic run_random(input int beat_count);
        int goal;
        int len;
        goal = beats_sent + beat_count;
        while (beats_sent < goal)
        begin
            rx_calm = ($urandom_range(0, 5) == 0);
            res_calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 7)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
                                                  : $urandom_range(0, 16);
                send_frame(len, $urandom_range(0, 3) != 0,
                           ($urandom_range(0, 2) == 0) ? 8 : 0);
            end
            else
            begin
                send_noise();
            end
        end
    endtask

    task automatic drain();
        rx_if.valid <= 1'b0;
        while (sb.pending_events.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [7:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.timeout = value;
    endtask

    // result side
    initial
    begin
        int           stall;
        frame_event_t got;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = res_calm ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!(res_if.valid === 1'b1 && res_if.ready));
            got.event_res = res_if.event_res;
            got.data_byte = res_if.data_byte;
            got.byte_index = res_if.byte_index;
            got.frame_length = res_if.frame_length;
            got.received_checksum = res_if.received_checksum;
            got.computed_checksum = res_if.computed_checksum;
            sb.check(got);
        end
    end

    // line side
    initial
    begin
        sb = new();
        cycles = 0;
        beats_sent = 0;
        rx_calm = 0;
        res_calm = 0;
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        rx_if.valid <= 1'b0;
        rx_if.kind <= KIND_BYTE;
        rx_if.rx_byte <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes outside a frame, then a good frame with a stuffed payload byte
        send_byte(8'hFF);
        send_tick();
        send_escaped(START_BYTE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_escaped(ESC_BYTE);
        send_escaped(END_BYTE);
        send_byte(8'h0F);
        send_byte(8'h01);
        // end marker while idle, escape with an unknown byte
        send_escaped(END_BYTE);
        send_escaped(8'h55);
        // restart mid-frame, stuffed checksum byte
        send_escaped(START_BYTE);
        send_byte(START_BYTE);
        send_byte(END_BYTE);
        send_escaped(START_BYTE);
        send_escaped(ESC_BYTE);
        send_escaped(END_BYTE);
        send_escaped(ESC_BYTE);
        send_byte(8'h00);
        // checksum mismatch
        send_escaped(START_BYTE);
        send_byte(8'h80);
        send_escaped(END_BYTE);
        send_byte(8'h00);
        send_byte(8'h00);
        // over-long frame
        send_frame(MAX_PAYLOAD + 1, 1, 0);
        drain();

        write_timeout(8'd255);
        run_random(350);
        drain();

        write_timeout(8'd1);
        run_random(250);
        drain();

        write_timeout(8'($urandom_range(2, 12)));
        run_random(400);
        drain();

        write_timeout(8'($urandom_range(1, 255)));
        run_random(400);
        drain();

        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("dle_frame_receiver: match");
        else
            $display("dle_frame_receiver: mismatch");
        $finish;
    end

endmodule
